### rtl/core/mono_framebuffer_line_draw_top_macros.svh
// Assertion macros used by the checker of the line drawing engine.
`ifndef MONO_FRAMEBUFFER_LINE_DRAW_TOP_MACROS_SVH
`define MONO_FRAMEBUFFER_LINE_DRAW_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFLD_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line draw check failed");

// The consequent must hold in the cycle after the antecedent.
`define MFLD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line draw check failed");

`endif

### rtl/core/mfld_pkg.sv
package mfld_pkg;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
  localparam int STORE_SIZE     = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int ADDR_W         = $clog2(STORE_SIZE);
  localparam int COORD_W        = 8;
  localparam int ACC_W          = COORD_W + 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [2:0] CMD_LINE  = 3'd0;
  localparam logic [2:0] CMD_RECT  = 3'd1;
  localparam logic [2:0] CMD_FILL  = 3'd2;
  localparam logic [2:0] CMD_CLEAR = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  typedef enum logic [2:0] {
    KIND_LINE,
    KIND_RECT,
    KIND_FILL,
    KIND_CLEAR,
    KIND_READ,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] xs;
    logic [COORD_W-1:0] ys;
    logic [COORD_W-1:0] xe;
    logic [COORD_W-1:0] ye;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] h;
    logic               color;
    logic [ADDR_W-1:0]  raddr;
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] xa;
    logic [COORD_W-1:0] ya;
    logic [COORD_W-1:0] xb;
    logic [COORD_W-1:0] yb;
  } seg_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pix_t;

endpackage

### rtl/core/mfld_queue.sv
module mfld_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mfld_pkg::cmd_t din,
  input  logic          pop,
  output mfld_pkg::cmd_t dout,
  output logic          full,
  output logic          empty
);

  mfld_pkg::cmd_t entries [mfld_pkg::QUEUE_DEPTH];
  logic [mfld_pkg::QPTR_W-1:0] wr_ptr;
  logic [mfld_pkg::QPTR_W-1:0] rd_ptr;
  logic [mfld_pkg::QPTR_W:0]   count;

  localparam logic [mfld_pkg::QPTR_W-1:0] PTR_LAST =
    mfld_pkg::QPTR_W'(mfld_pkg::QUEUE_DEPTH - 1);
  localparam logic [mfld_pkg::QPTR_W:0] COUNT_FULL =
    (mfld_pkg::QPTR_W + 1)'(mfld_pkg::QUEUE_DEPTH);

  assign full  = (count == COUNT_FULL);
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/mfld_front.sv
module mfld_front (
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  logic [2:0]                   command,
  input  logic [mfld_pkg::COORD_W-1:0] x_start,
  input  logic [mfld_pkg::COORD_W-1:0] y_start,
  input  logic [mfld_pkg::COORD_W-1:0] x_end,
  input  logic [mfld_pkg::COORD_W-1:0] y_end,
  input  logic [mfld_pkg::COORD_W-1:0] rect_width,
  input  logic [mfld_pkg::COORD_W-1:0] rect_height,
  input  logic                         color,
  input  logic [2:0]                   read_page,
  input  logic [6:0]                   read_column,
  input  logic                         q_full,
  input  logic                         init_busy,
  output logic                         push,
  output mfld_pkg::cmd_t               entry
);

  logic read_ok;

  assign cmd_stall = q_full || init_busy;
  assign push      = cmd_valid && !cmd_stall;
  assign read_ok   = (int'(read_page) < mfld_pkg::PAGE_COUNT) &&
                     (int'(read_column) < mfld_pkg::DISPLAY_WIDTH);

  always_comb begin
    entry.xs     = x_start;
    entry.ys     = y_start;
    entry.xe     = x_end;
    entry.ye     = y_end;
    entry.right  = x_start + rect_width + {mfld_pkg::COORD_W{1'b1}};
    entry.bottom = y_start + rect_height + {mfld_pkg::COORD_W{1'b1}};
    entry.h      = rect_height;
    entry.color  = color;
    entry.raddr  = mfld_pkg::ADDR_W'(int'(read_page) * mfld_pkg::DISPLAY_WIDTH
                                     + int'(read_column));
    unique case (command)
      mfld_pkg::CMD_LINE:  entry.kind = mfld_pkg::KIND_LINE;
      mfld_pkg::CMD_RECT:  entry.kind = mfld_pkg::KIND_RECT;
      mfld_pkg::CMD_FILL:  entry.kind = mfld_pkg::KIND_FILL;
      mfld_pkg::CMD_CLEAR: entry.kind = mfld_pkg::KIND_CLEAR;
      mfld_pkg::CMD_READ:  entry.kind = read_ok ? mfld_pkg::KIND_READ : mfld_pkg::KIND_NOP;
      default:             entry.kind = mfld_pkg::KIND_NOP;
    endcase
  end

endmodule

### rtl/core/mfld_line.sv
module mfld_line (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  mfld_pkg::seg_t  seg,
  output mfld_pkg::pix_t  pix
);

  localparam int AW = mfld_pkg::ACC_W;
  localparam int CW = mfld_pkg::COORD_W;

  logic                 busy;
  logic [CW-1:0]        px, py, qx, qy;
  logic                 sx, sy;
  logic signed [AW-1:0] run, rise, acc;
  logic signed [AW-1:0] run_next, rise_next, acc_next;
  logic [AW-1:0]        adx, ady;
  logic signed [AW:0]   twice;
  logic                 step_x, step_y, last;

  always_comb begin
    adx = (seg.xb > seg.xa) ? AW'(seg.xb - seg.xa) : AW'(seg.xa - seg.xb);
    ady = (seg.yb > seg.ya) ? AW'(seg.yb - seg.ya) : AW'(seg.ya - seg.yb);
    run_next  = $signed(adx);
    rise_next = $signed(AW'(0) - ady);
    twice     = $signed({acc, 1'b0});
    step_x    = (twice >= rise);
    step_y    = (twice <= run);
    acc_next  = acc + (step_x ? rise : AW'(0)) + (step_y ? run : AW'(0));
    last      = (px == qx) && (py == qy);
  end

  assign pix.valid = busy;
  assign pix.last  = last;
  assign pix.x     = px;
  assign pix.y     = py;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      px   <= seg.xa;
      py   <= seg.ya;
      qx   <= seg.xb;
      qy   <= seg.yb;
      sx   <= (seg.xa < seg.xb);
      sy   <= (seg.ya < seg.yb);
      run  <= run_next;
      rise <= rise_next;
      acc  <= run_next + rise_next;
    end else if (busy) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        acc <= acc_next;
        if (step_x) begin
          px <= sx ? px + 1'b1 : px - 1'b1;
        end
        if (step_y) begin
          py <= sy ? py + 1'b1 : py - 1'b1;
        end
      end
    end
  end

endmodule

### rtl/core/mfld_back.sv
module mfld_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  mfld_pkg::cmd_t       q_head,
  output logic                 pop,
  output logic                 init_busy,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [7:0]           read_data
);

  localparam int AW = mfld_pkg::ADDR_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(mfld_pkg::STORE_SIZE - 1);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LAUNCH,
    ST_SEG,
    ST_CLEAR,
    ST_READ,
    ST_READ_WAIT,
    ST_RESULT
  } state_t;

  state_t         state;
  mfld_pkg::cmd_t cur;
  logic [1:0]     seg_idx;
  logic [7:0]     row_cnt;
  logic [AW-1:0]  clr_cnt;
  logic [7:0]     data;

  mfld_pkg::seg_t seg;
  mfld_pkg::pix_t pix;
  logic           seg_final;
  logic [7:0]     row;

  logic [7:0]     mem [mfld_pkg::STORE_SIZE];
  logic [7:0]     rd;
  logic           we;
  logic [AW-1:0]  wa, ra;
  logic [7:0]     wd;

  logic           pix_in;
  logic [AW-1:0]  pix_addr;
  logic           s2_valid, s2_color;
  logic [AW-1:0]  s2_addr;
  logic [7:0]     s2_mask;
  logic           fwd_valid;
  logic [AW-1:0]  fwd_addr;
  logic [7:0]     fwd_data;
  logic [7:0]     base, merged;
  logic           clearing;

  assign pop       = (state == ST_IDLE) && !q_empty;
  assign init_busy = (state == ST_INIT);
  assign clearing  = (state == ST_INIT) || (state == ST_CLEAR);

  mfld_line u_line (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_LAUNCH),
    .seg   (seg),
    .pix   (pix)
  );

  always_comb begin
    row = cur.ys + row_cnt;
    seg = '{xa: cur.xs, ya: cur.ys, xb: cur.xe, yb: cur.ye};
    seg_final = 1'b1;
    unique case (cur.kind)
      mfld_pkg::KIND_RECT: begin
        seg_final = (seg_idx == 2'd3);
        unique case (seg_idx)
          2'd0: seg = '{xa: cur.xs, ya: cur.ys, xb: cur.right, yb: cur.ys};
          2'd1: seg = '{xa: cur.xs, ya: cur.bottom, xb: cur.right, yb: cur.bottom};
          2'd2: seg = '{xa: cur.xs, ya: cur.ys, xb: cur.xs, yb: cur.bottom};
          2'd3: seg = '{xa: cur.right, ya: cur.ys, xb: cur.right, yb: cur.bottom};
        endcase
      end
      mfld_pkg::KIND_FILL: begin
        seg_final = (row_cnt == cur.h - 8'd1);
        seg = '{xa: cur.xs, ya: row, xb: cur.right, yb: row};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pix_in   = pix.valid && (int'(pix.x) < mfld_pkg::DISPLAY_WIDTH) &&
               (int'(pix.y) < mfld_pkg::DISPLAY_HEIGHT);
    pix_addr = AW'((int'(pix.y) >> 3) * mfld_pkg::DISPLAY_WIDTH + int'(pix.x));
    base     = (fwd_valid && (fwd_addr == s2_addr)) ? fwd_data : rd;
    merged   = s2_color ? (base | s2_mask) : (base & ~s2_mask);
    ra       = (state == ST_READ) ? cur.raddr : pix_addr;
    we       = clearing || s2_valid;
    wa       = clearing ? clr_cnt : s2_addr;
    wd       = clearing ? 8'd0 : merged;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s2_valid  <= pix_in;
      fwd_valid <= s2_valid;
    end
    s2_addr  <= pix_addr;
    s2_mask  <= 8'd1 << pix.y[2:0];
    s2_color <= cur.color;
    fwd_addr <= s2_addr;
    fwd_data <= merged;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      clr_cnt   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !res_stall && (state != ST_RESULT)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_INIT, ST_CLEAR: begin
          clr_cnt <= (clr_cnt == CLR_LAST) ? '0 : clr_cnt + 1'b1;
          if (clr_cnt == CLR_LAST) begin
            state <= (state == ST_INIT) ? ST_IDLE : ST_RESULT;
          end
        end
        ST_IDLE: begin
          if (!q_empty) begin
            cur     <= q_head;
            seg_idx <= '0;
            row_cnt <= '0;
            data    <= '0;
            unique case (q_head.kind)
              mfld_pkg::KIND_LINE:  state <= ST_LAUNCH;
              mfld_pkg::KIND_RECT:  state <= ST_LAUNCH;
              mfld_pkg::KIND_FILL:  state <= (q_head.h == 8'd0) ? ST_RESULT : ST_LAUNCH;
              mfld_pkg::KIND_CLEAR: state <= ST_CLEAR;
              mfld_pkg::KIND_READ:  state <= ST_READ;
              mfld_pkg::KIND_NOP:   state <= ST_RESULT;
            endcase
          end
        end
        ST_LAUNCH: state <= ST_SEG;
        ST_SEG: begin
          if (pix.valid && pix.last) begin
            if (seg_final) begin
              state <= ST_RESULT;
            end else begin
              state   <= ST_LAUNCH;
              seg_idx <= seg_idx + 1'b1;
              row_cnt <= row_cnt + 1'b1;
            end
          end
        end
        ST_READ: state <= ST_READ_WAIT;
        ST_READ_WAIT: begin
          data  <= rd;
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            read_data <= data;
            state     <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

### rtl/core/mono_framebuffer_line_draw_top.sv
// Drawing engine over a 128 by 64 monochrome framebuffer kept in page order.
// The cmd channel takes one command word (line, rectangle outline, filled
// rectangle, clear, read byte); the res channel returns one word per command,
// read_data, which holds the stored byte for a read and zero otherwise.
// Commands enter a two-word queue, so up to two wait while one is drawn.
// A line's pixels come from the walker, one pixel per cycle, after dispatch
// and launch, and the result register then returns the command's word.
// A rectangle outline is four such lines, a filled rectangle one line per
// row, a clear sweeps the 1024-byte store, and a read fetches one stored
// byte. The walker and the single store write port set the drawing speed.
// After reset the store is swept to zero; cmd_stall stays high during that
// sweep. When res_stall is high the finished word is held in the
// output register, and the engine waits with its next result until it is
// taken, while the queue keeps taking commands until it is full.
module mono_framebuffer_line_draw_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  logic [2:0] command,
  input  logic [7:0] x_start,
  input  logic [7:0] y_start,
  input  logic [7:0] x_end,
  input  logic [7:0] y_end,
  input  logic [7:0] rect_width,
  input  logic [7:0] rect_height,
  input  logic       color,
  input  logic [2:0] read_page,
  input  logic [6:0] read_column,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] read_data
);

  mfld_pkg::cmd_t entry, head;
  logic           push, pop, q_full, q_empty, init_busy;

  mfld_front u_front (
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .command     (command),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .color       (color),
    .read_page   (read_page),
    .read_column (read_column),
    .q_full      (q_full),
    .init_busy   (init_busy),
    .push        (push),
    .entry       (entry)
  );

  mfld_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (entry),
    .pop   (pop),
    .dout  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  mfld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (head),
    .pop       (pop),
    .init_busy (init_busy),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .read_data (read_data)
  );

endmodule

### rtl/core/mfld_checker.sv
`include "mono_framebuffer_line_draw_top_macros.svh"

module mfld_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] read_data
);

  localparam logic [2:0] OUT_MAX = 3'(mfld_pkg::QUEUE_DEPTH + 2);

  logic [2:0] outstanding;
  logic       took_cmd, gave_res;

  assign took_cmd = cmd_valid && !cmd_stall;
  assign gave_res = res_valid && !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (took_cmd && !gave_res) begin
      outstanding <= outstanding + 1'b1;
    end else if (gave_res && !took_cmd) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  `MFLD_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(read_data))
  `MFLD_ASSERT_HOLDS(a_res_owed, res_valid, outstanding != 3'd0)
  `MFLD_ASSERT_HOLDS(a_bound, 1'b1, outstanding <= OUT_MAX)
  `MFLD_ASSERT_HOLDS(a_init_stall, $past(rst), cmd_stall)

endmodule

bind mono_framebuffer_line_draw_top mfld_checker u_checker (.*);
